// ===== hdl/mne_pkg.sv =====
// ----------------------------------------------------------------------------
// mne_pkg: shared definitions for the MIDI note event encoder
// Types, sizes and codes used by the event controller and the byte serializer.
// ----------------------------------------------------------------------------
package mne_pkg;

  // Default number of tracks.
  localparam int TRACKS_DEF = 16;

  // Longest byte run one item can cause: a four-byte delta, three note-off
  // bytes, then a one-byte zero delta and three note-on bytes.
  localparam int MAX_BYTES = 11;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // Input operation codes.
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // MIDI status bytes, channel 0.
  localparam logic [7:0] NOTE_ON  = 8'h90;
  localparam logic [7:0] NOTE_OFF = 8'h80;

  // Saturation value of the per-track tick counters.
  localparam logic [27:0] TICK_MAX = 28'hFFFFFFF;

  typedef logic [7:0] byte_t;

  // Byte run handed from the controller to the serializer.
  typedef struct packed {
    logic                        load;
    logic [CNT_W-1:0]            cnt;
    logic [3:0]                  track;
    byte_t [MAX_BYTES-1:0]       bytes;
  } mne_load_t;

endpackage

// ===== hdl/mne_event_ctrl.sv =====
// ----------------------------------------------------------------------------
// mne_event_ctrl: input register, per-track state and event decision
// Registers one item, decides what it causes against the track state and
// builds the complete byte run for the serializer in a single pass.
// ----------------------------------------------------------------------------
module mne_event_ctrl #(
  parameter int TRACKS = mne_pkg::TRACKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [31:0]       s_tdata,
  input  logic              ser_free,
  output mne_pkg::mne_load_t ld
);

  localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  typedef struct packed {
    logic [2:0]            len;
    mne_pkg::byte_t [3:0]  b;
  } vlq_t;

  // Big-endian MIDI variable-length quantity of a 28-bit count.
  function automatic vlq_t vlq_encode(input logic [27:0] t);
    vlq_t r;
    r.b = '0;
    if (t[27:21] != 7'd0) begin
      r.len  = 3'd4;
      r.b[0] = {1'b1, t[27:21]};
      r.b[1] = {1'b1, t[20:14]};
      r.b[2] = {1'b1, t[13:7]};
      r.b[3] = {1'b0, t[6:0]};
    end else if (t[20:14] != 7'd0) begin
      r.len  = 3'd3;
      r.b[0] = {1'b1, t[20:14]};
      r.b[1] = {1'b1, t[13:7]};
      r.b[2] = {1'b0, t[6:0]};
    end else if (t[13:7] != 7'd0) begin
      r.len  = 3'd2;
      r.b[0] = {1'b1, t[13:7]};
      r.b[1] = {1'b0, t[6:0]};
    end else begin
      r.len  = 3'd1;
      r.b[0] = {1'b0, t[6:0]};
    end
    return r;
  endfunction

  // Octave and semitone to MIDI pitch, clamped to the C-1..G9 range.
  function automatic logic [6:0] make_pitch(input logic signed [4:0] oct,
                                            input logic signed [4:0] nt);
    logic signed [4:0] oc;
    logic signed [4:0] nc;
    logic [3:0]        o1;
    logic [7:0]        p;
    oc = oct;
    if (oct < -5'sd1) oc = -5'sd1;
    if (oct > 5'sd9)  oc = 5'sd9;
    nc = nt;
    if (nt < 5'sd0)  nc = 5'sd0;
    if (nt > 5'sd11) nc = 5'sd11;
    if (oc == 5'sd9 && nc > 5'sd7) nc = 5'sd7;
    o1 = 4'(oc + 5'sd1);
    p  = 8'(o1) * 8'd12 + 8'(nc);
    return p[6:0];
  endfunction

  // Q12 loudness to velocity: floor(min(l, 4096) * 127 / 4096).
  function automatic logic [6:0] make_velocity(input logic [12:0] l);
    logic [12:0] lc;
    logic [19:0] prod;
    lc   = (l > 13'd4096) ? 13'd4096 : l;
    prod = {lc, 7'd0} - 20'(lc);
    return prod[18:12];
  endfunction

  // Input register.
  logic                in_valid;
  logic [1:0]          in_op;
  logic [3:0]          in_track;
  logic signed [4:0]   in_octave;
  logic signed [4:0]   in_note;
  logic [12:0]         in_loudness;

  // Per-track state.
  logic [TRACKS-1:0]   held_flag;
  logic [6:0]          held_pitch [TRACKS];
  logic [27:0]         ticks      [TRACKS];

  logic [IW-1:0]       idx;
  logic                trk_ok;
  logic                cur_flag;
  logic [6:0]          cur_pitch;
  logic [27:0]         cur_ticks;
  logic [6:0]          pitch;
  logic [6:0]          vel;
  logic                is_press;
  logic                is_release;
  logic                is_tick;
  logic                emit;
  logic                go;
  vlq_t                dv;
  mne_pkg::byte_t      k_status;
  mne_pkg::byte_t      k_d1;
  mne_pkg::byte_t      k_d2;
  logic [mne_pkg::CNT_W-1:0] l1;
  logic [mne_pkg::CNT_W-1:0] l2;
  logic [mne_pkg::CNT_W-1:0] jj;
  mne_pkg::byte_t [mne_pkg::MAX_BYTES-1:0] e1;
  mne_pkg::byte_t [3:0]                    e2;

  assign idx        = IW'(in_track);
  assign trk_ok     = (32'(in_track) < TRACKS);
  assign cur_flag   = held_flag[idx];
  assign cur_pitch  = held_pitch[idx];
  assign cur_ticks  = ticks[idx];
  assign pitch      = make_pitch(in_octave, in_note);
  assign vel        = make_velocity(in_loudness);
  assign is_press   = (in_op == mne_pkg::OP_PRESS) && trk_ok;
  assign is_release = (in_op == mne_pkg::OP_RELEASE) && trk_ok;
  assign is_tick    = (in_op == mne_pkg::OP_TICK);
  assign emit       = (is_press && !(cur_flag && cur_pitch == pitch)) ||
                      (is_release && cur_flag);
  assign go         = in_valid && (!emit || ser_free);
  assign s_tready   = !in_valid || go;
  assign dv         = vlq_encode(cur_ticks);

  always_comb begin
    // The first event is a note-off whenever a note is held.
    if (cur_flag) begin
      k_status = mne_pkg::NOTE_OFF;
      k_d1     = {1'b0, cur_pitch};
      k_d2     = 8'h00;
    end else begin
      k_status = mne_pkg::NOTE_ON;
      k_d1     = {1'b0, pitch};
      k_d2     = {1'b0, vel};
    end
    l1 = mne_pkg::CNT_W'(dv.len) + mne_pkg::CNT_W'(3);
    l2 = (is_press && cur_flag) ? mne_pkg::CNT_W'(4) : '0;
    e2 = {{1'b0, vel}, {1'b0, pitch}, mne_pkg::NOTE_ON, 8'h00};
    for (int i = 0; i < mne_pkg::MAX_BYTES; i++) begin
      if (mne_pkg::CNT_W'(i) < mne_pkg::CNT_W'(dv.len)) begin
        e1[i] = dv.b[i % 4];
      end else if (mne_pkg::CNT_W'(i) == mne_pkg::CNT_W'(dv.len)) begin
        e1[i] = k_status;
      end else if (mne_pkg::CNT_W'(i) == mne_pkg::CNT_W'(dv.len) + 1'b1) begin
        e1[i] = k_d1;
      end else if (mne_pkg::CNT_W'(i) == mne_pkg::CNT_W'(dv.len) + 2'd2) begin
        e1[i] = k_d2;
      end else begin
        e1[i] = 8'h00;
      end
    end
    ld.load  = go && emit;
    ld.cnt   = l1 + l2;
    ld.track = in_track;
    jj       = '0;
    for (int i = 0; i < mne_pkg::MAX_BYTES; i++) begin
      jj = mne_pkg::CNT_W'(i) - l1;
      if (mne_pkg::CNT_W'(i) < l1) begin
        ld.bytes[i] = e1[i];
      end else if (jj < mne_pkg::CNT_W'(4)) begin
        ld.bytes[i] = e2[jj[1:0]];
      end else begin
        ld.bytes[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op       <= s_tdata[1:0];
      in_track    <= s_tdata[5:2];
      in_octave   <= s_tdata[10:6];
      in_note     <= s_tdata[15:11];
      in_loudness <= s_tdata[28:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag <= '0;
      for (int k = 0; k < TRACKS; k++) begin
        held_pitch[k] <= 7'd0;
        ticks[k]      <= 28'd0;
      end
    end else if (go) begin
      if (is_tick) begin
        for (int k = 0; k < TRACKS; k++) begin
          if (ticks[k] != mne_pkg::TICK_MAX) begin
            ticks[k] <= ticks[k] + 28'd1;
          end
        end
      end else if (emit) begin
        ticks[idx] <= 28'd0;
        if (is_press) begin
          held_flag[idx]  <= 1'b1;
          held_pitch[idx] <= pitch;
        end else begin
          held_flag[idx]  <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== hdl/mne_byte_serializer.sv =====
// ----------------------------------------------------------------------------
// mne_byte_serializer: output byte queue
// Holds one byte run and sends it one item per cycle on the output stream while m_tready is high.
// ----------------------------------------------------------------------------
module mne_byte_serializer (
  input  logic               clk,
  input  logic               rst,
  input  mne_pkg::mne_load_t ld,
  output logic               ser_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,
  output logic               m_tlast
);

  mne_pkg::byte_t [mne_pkg::MAX_BYTES-1:0] bytes;
  logic [mne_pkg::CNT_W-1:0]               cnt;
  logic [3:0]                              track;

  assign m_tvalid = (cnt != '0);
  assign m_tlast  = (cnt == mne_pkg::CNT_W'(1));
  assign m_tdata  = {4'd0, track, bytes[0]};
  // A new run may enter as the last byte of the current one leaves.
  assign ser_free = (cnt == '0) || (m_tlast && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ld.load) begin
      cnt <= ld.cnt;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      bytes <= ld.bytes;
      track <= ld.track;
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < mne_pkg::MAX_BYTES - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> ser_free)
    else $error("byte run loaded over a run still being sent");

  a_load_length: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> (ld.cnt >= mne_pkg::CNT_W'(4) && ld.cnt <= mne_pkg::CNT_W'(mne_pkg::MAX_BYTES)))
    else $error("byte run length out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= mne_pkg::CNT_W'(mne_pkg::MAX_BYTES))
    else $error("byte count beyond queue depth");

endmodule

// ===== hdl/midi_note_event_encoder_unit.sv =====
// Flow: an accepted item that causes bytes waits in the input register until
// the byte queue is free; its byte run is then loaded into the queue, which
// sends one byte per cycle while m_tready is high.
// Throughput: one item per cycle for ticks and items that cause no bytes
// while no event waits for the byte queue; an event's run is 4 to 11 bytes.
// Reset clears all track state (held notes, tick counters).
// ----------------------------------------------------------------------------
// midi_note_event_encoder_unit: per-track MIDI note event byte encoder
// Turns key presses, key releases and ticks into delta-time and note bytes.
// ----------------------------------------------------------------------------
module midi_note_event_encoder_unit #(
  parameter int TRACKS = mne_pkg::TRACKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0 up: op[1:0], track[5:2], octave[10:6], note[15:11],
  // loudness[28:16], zero fill[31:29].
  input  logic [31:0] s_tdata,
  // Result items, one byte each.
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0 up: data_byte[7:0], out_track[11:8], zero fill[15:12].
  output logic [15:0] m_tdata,
  // Set on the final byte caused by one input item.
  output logic        m_tlast
);

  // The controller registers each item, looks up the track's held note and
  // tick counter, and builds the whole byte run at once: the delta time of
  // the track, a note-off for a held note when one is sounding, and for a
  // press the note-on (after a zero delta if a note-off went first).
  // A press of the note already held and a release with nothing held cause
  // no bytes, as do ticks, unused op codes and tracks out of range.

  mne_pkg::mne_load_t ld;
  logic               ser_free;

  mne_event_ctrl #(
    .TRACKS(TRACKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .ser_free (ser_free),
    .ld       (ld)
  );

  // The serializer sends the run while the controller goes on taking ticks
  // and silent items; the next run enters as the last byte leaves.
  mne_byte_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .ser_free (ser_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/sv/midi_note_event_encoder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_event_encoder_unit_tb: self-checking bench for the note encoder
// Drives presses, releases, ticks and unused op codes under random input gaps
// and output stalls, predicts or is given every event byte and compares each one as it leaves.
// ----------------------------------------------------------------------------
module midi_note_event_encoder_unit_tb;

  localparam logic [1:0]  OP_SPARE      = 2'd3;
  localparam logic [27:0] TICK_SAT      = 28'hFFFFFFF;
  localparam int          FULL_SCALE    = 4096;
  localparam int          RANDOM_ITEMS  = 105;
  localparam int          CHOKE_CYCLES  = 300;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          CYCLE_LIMIT   = 500000;

  // One input item; the last field sits in the lowest bits.
  typedef struct packed {
    logic [12:0]       loudness;
    logic signed [4:0] note;
    logic signed [4:0] octave;
    logic [3:0]        track;
    logic [1:0]        op;
  } key_item_t;

  typedef struct {
    logic [7:0] data_byte;
    logic [3:0] out_track;
    logic       last;
  } midi_byte_t;

  typedef struct {
    key_item_t   item;
    int          reps;
    bit          typed;
    int          n_typed;
    logic [63:0] typed_bytes;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // Per-track state of the predictor.
  logic        note_held  [mne_pkg::TRACKS_DEF];
  logic [6:0]  held_key   [mne_pkg::TRACKS_DEF];
  logic [27:0] idle_ticks [mne_pkg::TRACKS_DEF];

  midi_byte_t  expected_bytes[$];
  midi_byte_t  event_bytes[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          burst_left     = 0;
  bit          choke_req      = 1'b0;
  bit          choke_done     = 1'b0;
  longint      cycle_count    = 0;

  midi_note_event_encoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Event byte predictor
  // ---------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] value, input logic [3:0] trk);
    midi_byte_t e;
    e.data_byte = value;
    e.out_track = trk;
    e.last      = 1'b0;
    event_bytes.insert(event_bytes.size(), e);
  endfunction

  // Variable-length delta: 7-bit groups, most significant first, with the
  // continuation bit on every group but the last.
  function automatic void add_delta(input logic [27:0] ticks, input logic [3:0] trk);
    int top_group;
    top_group = 0;
    for (int g = 1; g < 4; g++)
      if ((ticks >> (7 * g)) != 0) top_group = g;
    for (int g = top_group; g >= 0; g--)
      add_byte({g != 0, ticks[7 * g +: 7]}, trk);
  endfunction

  function automatic logic [6:0] key_number(input logic signed [4:0] oct_in,
                                            input logic signed [4:0] note_in);
    int oct;
    int semi;
    oct  = oct_in;
    semi = note_in;
    if (oct < -1) oct = -1;
    if (oct > 9) oct = 9;
    if (semi < 0) semi = 0;
    if (semi > 11) semi = 11;
    // The top octave stops at G.
    if (oct == 9 && semi > 7) semi = 7;
    return 7'((oct + 1) * 12 + semi);
  endfunction

  function automatic logic [6:0] velocity_of(input logic [12:0] loud);
    int level;
    level = loud;
    if (level > FULL_SCALE) level = FULL_SCALE;
    return 7'(level * 127 / FULL_SCALE);
  endfunction

  function automatic void add_note_off(input logic [3:0] trk);
    add_delta(idle_ticks[trk], trk);
    add_byte(mne_pkg::NOTE_OFF, trk);
    add_byte({1'b0, held_key[trk]}, trk);
    add_byte(8'h00, trk);
    idle_ticks[trk] = '0;
  endfunction

  // Works out the bytes one accepted item causes and updates the state.
  function automatic void encode_event(input key_item_t it);
    logic [6:0] key;
    logic [6:0] vel;
    midi_byte_t tail;
    event_bytes.delete();
    case (it.op)
      mne_pkg::OP_TICK: begin
        for (int i = 0; i < mne_pkg::TRACKS_DEF; i++)
          if (idle_ticks[i] != TICK_SAT) idle_ticks[i]++;
      end
      mne_pkg::OP_PRESS: begin
        key = key_number(it.octave, it.note);
        vel = velocity_of(it.loudness);
        // A press of the pitch already sounding changes nothing.
        if (!(note_held[it.track] && held_key[it.track] == key)) begin
          if (note_held[it.track]) add_note_off(it.track);
          add_delta(idle_ticks[it.track], it.track);
          add_byte(mne_pkg::NOTE_ON, it.track);
          add_byte({1'b0, key}, it.track);
          add_byte({1'b0, vel}, it.track);
          note_held[it.track]  = 1'b1;
          held_key[it.track]   = key;
          idle_ticks[it.track] = '0;
        end
      end
      mne_pkg::OP_RELEASE: begin
        if (note_held[it.track]) begin
          add_note_off(it.track);
          note_held[it.track] = 1'b0;
        end
      end
      default: ;
    endcase
    if (event_bytes.size() != 0) begin
      tail = event_bytes[event_bytes.size() - 1];
      tail.last = 1'b1;
      event_bytes[event_bytes.size() - 1] = tail;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_row(input logic [1:0] op, input int trk, input int oct,
                                  input int semi, input int loud, input int reps,
                                  input bit typed, input int n_typed,
                                  input logic [63:0] typed_bytes);
    stim_row_t row;
    row.item.op       = op;
    row.item.track    = 4'(trk);
    row.item.octave   = 5'(oct);
    row.item.note     = 5'(semi);
    row.item.loudness = 13'(loud);
    row.reps          = reps;
    row.typed         = typed;
    row.n_typed       = n_typed;
    row.typed_bytes   = typed_bytes;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Offers one item, in bursts with random gaps between them. Typed bytes,
  // when given, stand in for the predicted ones; the state advances anyway.
  task automatic offer_item(input key_item_t it, input bit typed, input int n_typed,
                            input logic [63:0] typed_bytes);
    int gap;
    midi_byte_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_event(it);
    if (typed) begin
      for (int k = 0; k < n_typed; k++) begin
        e.data_byte = typed_bytes[63 - 8 * k -: 8];
        e.out_track = it.track;
        e.last      = (k == n_typed - 1);
        expected_bytes.insert(expected_bytes.size(), e);
      end
    end else begin
      foreach (event_bytes[k]) expected_bytes.insert(expected_bytes.size(), event_bytes[k]);
    end
  endtask

  // Mostly well-formed presses and releases on a few busy tracks, with
  // re-presses of the sounding pitch, ticks, and some unused op codes.
  function automatic key_item_t random_item();
    key_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.track    = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3))
                                              : 4'($urandom_range(0, 15));
    it.octave   = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 10) - 1)
                                              : 5'($urandom_range(0, 23) - 8);
    it.note     = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 11))
                                              : 5'($urandom_range(0, 31));
    case ($urandom_range(0, 2))
      0:       it.loudness = 13'($urandom_range(0, 8191));
      1:       it.loudness = 13'($urandom_range(4000, 4200));
      default: it.loudness = 13'($urandom_range(0, 300));
    endcase
    if (pick < 40) begin
      it.op = mne_pkg::OP_PRESS;
    end else if (pick < 50) begin
      it.op = mne_pkg::OP_PRESS;
      if (note_held[it.track]) begin
        it.octave = 5'(int'(held_key[it.track]) / 12 - 1);
        it.note   = 5'(int'(held_key[it.track]) % 12);
      end
    end else if (pick < 75) begin
      it.op = mne_pkg::OP_RELEASE;
    end else if (pick < 95) begin
      it.op = mne_pkg::OP_TICK;
    end else begin
      it.op = OP_SPARE;
    end
    return it;
  endfunction

  initial begin
    stim_row_t row;
    key_item_t tick_item;
    for (int i = 0; i < mne_pkg::TRACKS_DEF; i++) begin
      note_held[i]  = 1'b0;
      held_key[i]   = '0;
      idle_ticks[i] = '0;
    end

    // Lowest pitch and silent velocity straight after reset.
    add_row(mne_pkg::OP_PRESS,   0, -1,   0,    0, 1, 1, 4, 64'h00900000_00000000);
    // Clamps land on the same pitch, so the press does nothing.
    add_row(mne_pkg::OP_PRESS,   0, -8, -16, 8191, 1, 1, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 0,  0,   0,    0, 1, 1, 4, 64'h00800000_00000000);
    // Release with nothing held.
    add_row(mne_pkg::OP_RELEASE, 0,  0,   0,    0, 1, 1, 0, '0);
    // Highest pitch G9 at full scale.
    add_row(mne_pkg::OP_PRESS,   1,  9,  11, 4096, 1, 1, 4, 64'h00907F7F_00000000);
    add_row(mne_pkg::OP_PRESS,   1, 15,  15, 8191, 1, 1, 0, '0);
    add_row(mne_pkg::OP_TICK,    5,  3,   3,  100, 1, 1, 0, '0);
    // New pitch while holding: note-off first, then note-on with zero delta.
    add_row(mne_pkg::OP_PRESS,   1,  4,   0, 2048, 1, 1, 8, 64'h01807F00_00903C3F);
    // The single tick above also counts for this track.
    add_row(mne_pkg::OP_PRESS,   2, -8, -16,    1, 1, 1, 4, 64'h01900000_00000000);
    add_row(OP_SPARE,            3,  7,  -5, 8191, 1, 1, 0, '0);
    add_row(mne_pkg::OP_PRESS,  15,  5,   7, 4095, 1, 0, 0, '0);
    add_row(mne_pkg::OP_PRESS,   3,  0,  15, 4097, 1, 0, 0, '0);
    // Enough ticks for two-byte deltas.
    add_row(mne_pkg::OP_TICK,    9, -3,  -9, 8191, 130, 0, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 15, 0,   0,    0, 1, 0, 0, '0);
    add_row(mne_pkg::OP_PRESS,   2,  3,   3,  100, 1, 0, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 1,  0,   0,    0, 1, 0, 0, '0);
    add_row(mne_pkg::OP_PRESS,   3,  2,   2, 3000, 1, 0, 0, '0);
    add_row(mne_pkg::OP_PRESS,   4,  6,  -1,   50, 1, 0, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 3,  0,   0,    0, 1, 0, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 2,  0,   0,    0, 1, 0, 0, '0);
    add_row(mne_pkg::OP_RELEASE, 4,  0,   0,    0, 1, 0, 0, '0);
    add_row(mne_pkg::OP_PRESS,   1, -1,  11, 8190, 1, 0, 0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      repeat (row.reps) offer_item(row.item, row.typed, row.n_typed, row.typed_bytes);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Long output stall while items keep coming, so the block backs up.
      if (n == 20) choke_req = 1'b1;
      // Let the block drain completely once before going on.
      if (n == 60) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      // A short run of ticks now and then so deltas vary.
      if (n % 40 == 39) begin
        repeat ($urandom_range(4, 12)) begin
          tick_item          = random_item();
          tick_item.op       = mne_pkg::OP_TICK;
          offer_item(tick_item, 1'b0, 0, '0);
        end
      end
      offer_item(random_item(), 1'b0, 0, '0);
    end
    s_tvalid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, one long hold-off, and the byte checker
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       span;
    int       hold;
    mode = RX_OPEN;
    span = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (choke_req && !choke_done) begin
        choke_done = 1'b1;
        hold       = CHOKE_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          RX_OPEN:     m_tready <= 1'b1;
          RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: m_tready <= (span % 3 != 0);
          default:     m_tready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    midi_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: data_byte %02h out_track %0d last %0b",
               m_tdata[7:0], m_tdata[11:8], m_tlast);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.data_byte) begin
          $error("data_byte: expected %02h, actual %02h", want.data_byte, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tdata[11:8] !== want.out_track) begin
          $error("out_track: expected %0d, actual %0d", want.out_track, m_tdata[11:8]);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog for a block that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hdl/mne_pkg.sv
hdl/mne_event_ctrl.sv
hdl/mne_byte_serializer.sv
hdl/midi_note_event_encoder_unit.sv
tb/sv/midi_note_event_encoder_unit_tb.sv
